// ===== rtl/core/scope_waveform_decimator_top_defines.svh =====
// Assertion macros shared by the scope waveform decimator RTL.
// No dependencies; included by the top level.
`ifndef SCOPE_WAVEFORM_DECIMATOR_TOP_DEFINES_SVH
`define SCOPE_WAVEFORM_DECIMATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SWD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/swd_pkg.sv =====
// Shared types and constants for the scope waveform decimator.
// No dependencies.
`default_nettype none
package swd_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLES_PER_PIXEL = 3'd0,
        REG_REDUCE_MODE       = 3'd1,
        REG_SCALE_NUM         = 3'd2,
        REG_SCALE_DEN         = 3'd3,
        REG_VERT_OFFSET       = 3'd4,
        REG_RAW_ZERO          = 3'd5,
        REG_ZERO_PIXEL        = 3'd6
    } t_reg_idx;

    localparam logic [1:0] MODE_FIRST   = 2'd0;
    localparam logic [1:0] MODE_AVERAGE = 2'd1;
    localparam logic [1:0] MODE_PEAK    = 2'd2;

    localparam logic [12:0] MAX_GROUP = 13'd4096;

    // scaling settings seen by every lane
    typedef struct packed {
        logic [15:0]       num;
        logic [15:0]       den;
        logic signed [8:0] offset;
        logic [7:0]        raw_zero;
        logic [7:0]        zero_pixel;
    } t_lane_cfg;

    typedef struct packed {
        logic        start;
        logic [19:0] value;
        logic [12:0] divisor;
    } t_lane_req;

endpackage
`default_nettype wire

// ===== rtl/core/swd_lane.sv =====
// One reduction/scaling lane: divide by group size, scale, divide, clamp.
// Depends on swd_pkg.
`default_nettype none
module swd_lane
    import swd_pkg::*;
#(
    parameter int unsigned SCREEN_HEIGHT = 240
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_lane_req i_req,
    input  wire t_lane_cfg i_cfg,
    output logic [7:0]     o_row,
    output logic           o_done
);
    localparam logic [25:0] ROW_MAX = 26'(SCREEN_HEIGHT - 1);

    typedef enum logic [2:0] {L_IDLE, L_DIV1, L_MUL, L_DIV2, L_FIN} t_lstate;

    t_lstate     r_state;
    logic [23:0] r_quo;
    logic [16:0] r_rem;
    logic [15:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_neg;
    logic [7:0]  r_row;
    logic        r_done;

    logic [16:0] rem_sh, rem_nx;
    logic        ge;
    logic [23:0] quo_nx;
    logic signed [8:0]  diff;
    logic signed [25:0] prod;
    logic [24:0] mag;
    logic [25:0] qs, v, clamped;

    always_comb begin
        rem_sh = {r_rem[15:0], r_quo[23]};
        ge     = rem_sh >= {1'b0, r_dvs};
        rem_nx = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
        quo_nx = {r_quo[22:0], ge};
        diff   = $signed({1'b0, r_quo[7:0]}) - $signed({1'b0, i_cfg.raw_zero});
        prod   = $signed({1'b0, i_cfg.num}) * diff;
        mag    = prod[25] ? 25'(26'd0 - prod) : prod[24:0];
        qs     = r_neg ? (26'd0 - {2'b0, r_quo}) : {2'b0, r_quo};
        v      = qs + {{17{i_cfg.offset[8]}}, i_cfg.offset} + {18'd0, i_cfg.zero_pixel};
        if (v[25]) begin
            clamped = 26'd0;
        end else if (v > ROW_MAX) begin
            clamped = ROW_MAX;
        end else begin
            clamped = v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                L_IDLE: begin
                    r_done <= 1'b0;
                    if (i_req.start) begin
                        r_quo   <= {4'd0, i_req.value};
                        r_dvs   <= {3'd0, i_req.divisor};
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= L_DIV1;
                    end
                end
                L_DIV1: begin
                    r_rem <= rem_nx;
                    r_quo <= quo_nx;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd23) begin
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_neg   <= prod[25];
                    r_quo   <= mag[23:0];
                    r_dvs   <= (i_cfg.den == 16'd0) ? 16'd1 : i_cfg.den;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= L_DIV2;
                end
                L_DIV2: begin
                    r_rem <= rem_nx;
                    r_quo <= quo_nx;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd23) begin
                        r_state <= L_FIN;
                    end
                end
                L_FIN: begin
                    r_row   <= clamped[7:0];
                    r_done  <= 1'b1;
                    r_state <= L_IDLE;
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_row  = r_row;
    assign o_done = r_done;
endmodule
`default_nettype wire

// ===== rtl/core/scope_waveform_decimator_top.sv =====
// Scope waveform decimator: four scaling lanes plus group accumulator.
// Depends on swd_pkg, swd_lane and scope_waveform_decimator_top_defines.svh.
//
// Input channel: i_in_valid / o_in_stall carry one sample pair per transaction,
// with present and group_end flags. Output channel: o_out_valid / i_out_stall
// carry one display pixel (four rows, valid flag, last-column flag).
// A present sample that does not close its group is taken every cycle while
// input is not stalled. A closing sample starts the four lanes (A high/low,
// B high/low); each runs a 24-step average division, one multiply and a
// 24-step scale division, so the pixel lands in the pending register after
// the lane run, and moves on into the output register when that is free or
// the receiver is not stalling. Input is stalled for the lane run and until
// the pending register has moved on; an absent sample loads an invalid pixel
// straight into the pending register, which likewise stalls input.
// The pending register acts as a skid stage: while the output waits on a
// stalling receiver, it holds the next pixel and input is stalled.
// Reset (synchronous, active low) restores the register defaults, empties
// the group and the pixel registers and returns the column counter to 0.
// Configuration writes are taken at any edge with i_cfg_we high.
`default_nettype none
`include "scope_waveform_decimator_top_defines.svh"
module scope_waveform_decimator_top
    import swd_pkg::*;
#(
    parameter int unsigned SCREEN_WIDTH  = 320,
    parameter int unsigned SCREEN_HEIGHT = 240
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_sample_a,
    input  wire logic [7:0]            i_sample_b,
    input  wire logic                  i_present,
    input  wire logic                  i_group_end,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [7:0]                 o_pixel_a_high,
    output logic [7:0]                 o_pixel_a_low,
    output logic [7:0]                 o_pixel_b_high,
    output logic [7:0]                 o_pixel_b_low,
    output logic                       o_pixel_valid,
    output logic                       o_last_pixel
);
    localparam int unsigned COL_W = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_WIDTH - 1);

    // configuration
    logic [12:0] r_spp;
    logic [1:0]  r_mode;
    t_lane_cfg   r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spp            <= 13'd1;
            r_mode           <= MODE_FIRST;
            r_cfg.num        <= 16'd1;
            r_cfg.den        <= 16'd1;
            r_cfg.offset     <= 9'sd0;
            r_cfg.raw_zero   <= 8'd128;
            r_cfg.zero_pixel <= 8'd120;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SAMPLES_PER_PIXEL: r_spp            <= i_cfg_data[12:0];
                REG_REDUCE_MODE:       r_mode           <= i_cfg_data[1:0];
                REG_SCALE_NUM:         r_cfg.num        <= i_cfg_data;
                REG_SCALE_DEN:         r_cfg.den        <= i_cfg_data;
                REG_VERT_OFFSET:       r_cfg.offset     <= $signed(i_cfg_data[8:0]);
                REG_RAW_ZERO:          r_cfg.raw_zero   <= i_cfg_data[7:0];
                REG_ZERO_PIXEL:        r_cfg.zero_pixel <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // group accumulator
    logic [19:0] r_sum_a, r_sum_b;
    logic [7:0]  r_first_a, r_first_b, r_min_a, r_max_a, r_min_b, r_max_b;
    logic [12:0] r_cnt;

    logic [19:0] n_sum_a, n_sum_b;
    logic [7:0]  n_first_a, n_first_b, n_min_a, n_max_a, n_min_b, n_max_b;
    logic [12:0] n_cnt, gsize;
    logic        close, in_acc;

    always_comb begin
        n_sum_a   = r_sum_a + {12'd0, i_sample_a};
        n_sum_b   = r_sum_b + {12'd0, i_sample_b};
        n_first_a = (r_cnt == 13'd0) ? i_sample_a : r_first_a;
        n_first_b = (r_cnt == 13'd0) ? i_sample_b : r_first_b;
        n_min_a   = (i_sample_a < r_min_a) ? i_sample_a : r_min_a;
        n_max_a   = (i_sample_a > r_max_a) ? i_sample_a : r_max_a;
        n_min_b   = (i_sample_b < r_min_b) ? i_sample_b : r_min_b;
        n_max_b   = (i_sample_b > r_max_b) ? i_sample_b : r_max_b;
        n_cnt     = r_cnt + 13'd1;
        if (r_spp == 13'd0) begin
            gsize = 13'd1;
        end else if (r_spp > MAX_GROUP) begin
            gsize = MAX_GROUP;
        end else begin
            gsize = r_spp;
        end
        close = i_group_end || (n_cnt >= gsize);
    end

    // lanes and pixel registers
    logic             r_busy;
    t_lane_req        r_req [4];
    logic [7:0]       lane_row [4];
    logic [3:0]       lane_done;
    logic             r_pend_valid, r_pend_pv;
    logic [7:0]       r_pend_row [4];
    logic             r_pend_last;
    logic [COL_W-1:0] r_col;
    logic             col_last, pend_load, out_load;

    assign o_in_stall = r_busy || r_pend_valid;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign col_last   = (r_col == COL_LAST);
    assign pend_load  = lane_done[0] || (in_acc && !i_present);
    assign out_load   = r_pend_valid && (!o_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a <= '0; r_sum_b <= '0;
            r_first_a <= '0; r_first_b <= '0;
            r_min_a <= 8'hFF; r_min_b <= 8'hFF;
            r_max_a <= '0; r_max_b <= '0;
            r_cnt <= '0;
            r_busy <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_req[i].start <= 1'b0;
            end
        end else begin
            // one-cycle start pulse on a closing present sample
            for (int i = 0; i < 4; i++) begin
                r_req[i].start <= in_acc && i_present && close;
            end
            if (lane_done[0]) begin
                r_busy <= 1'b0;
            end
            if (in_acc) begin
                if (!i_present || close) begin
                    r_sum_a <= '0; r_sum_b <= '0;
                    r_first_a <= '0; r_first_b <= '0;
                    r_min_a <= 8'hFF; r_min_b <= 8'hFF;
                    r_max_a <= '0; r_max_b <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum_a <= n_sum_a; r_sum_b <= n_sum_b;
                    r_first_a <= n_first_a; r_first_b <= n_first_b;
                    r_min_a <= n_min_a; r_min_b <= n_min_b;
                    r_max_a <= n_max_a; r_max_b <= n_max_b;
                    r_cnt <= n_cnt;
                end
                if (i_present && close) begin
                    r_busy <= 1'b1;
                    // lane order: A high, A low, B high, B low
                    case (r_mode)
                        MODE_AVERAGE: begin
                            r_req[0].value <= n_sum_a; r_req[1].value <= n_sum_a;
                            r_req[2].value <= n_sum_b; r_req[3].value <= n_sum_b;
                        end
                        MODE_PEAK: begin
                            r_req[0].value <= {12'd0, n_max_a};
                            r_req[1].value <= {12'd0, n_min_a};
                            r_req[2].value <= {12'd0, n_max_b};
                            r_req[3].value <= {12'd0, n_min_b};
                        end
                        default: begin
                            r_req[0].value <= {12'd0, n_first_a};
                            r_req[1].value <= {12'd0, n_first_a};
                            r_req[2].value <= {12'd0, n_first_b};
                            r_req[3].value <= {12'd0, n_first_b};
                        end
                    endcase
                    for (int i = 0; i < 4; i++) begin
                        r_req[i].divisor <= (r_mode == MODE_AVERAGE) ? n_cnt : 13'd1;
                    end
                end
            end
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        swd_lane #(
            .SCREEN_HEIGHT(SCREEN_HEIGHT)
        ) u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_req  (r_req[g]),
            .i_cfg  (r_cfg),
            .o_row  (lane_row[g]),
            .o_done (lane_done[g])
        );
    end

    // merge: pending pixel (skid) then output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            o_out_valid  <= 1'b0;
            r_col        <= '0;
        end else begin
            if (pend_load) begin
                r_pend_valid <= 1'b1;
                r_pend_pv    <= lane_done[0];
                for (int i = 0; i < 4; i++) begin
                    r_pend_row[i] <= lane_done[0] ? lane_row[i] : 8'd0;
                end
                r_pend_last <= col_last;
                r_col       <= col_last ? '0 : r_col + COL_W'(1);
            end else if (out_load) begin
                r_pend_valid <= 1'b0;
            end
            if (out_load) begin
                o_out_valid    <= 1'b1;
                o_pixel_a_high <= r_pend_row[0];
                o_pixel_a_low  <= r_pend_row[1];
                o_pixel_b_high <= r_pend_row[2];
                o_pixel_b_low  <= r_pend_row[3];
                o_pixel_valid  <= r_pend_pv;
                o_last_pixel   <= r_pend_last;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    `SWD_ASSERT_NOW(a_lanes_lockstep, i_clk, i_rst_n, 1'b1,
        (lane_done == 4'h0) || (lane_done == 4'hF), "lanes finished out of step")
    `SWD_ASSERT_NOW(a_pend_free, i_clk, i_rst_n, lane_done[0],
        !r_pend_valid && r_busy, "lane result with pending pixel occupied")
    `SWD_ASSERT_NEXT(a_out_follows, i_clk, i_rst_n, out_load,
        o_out_valid, "pending pixel lost on its way out")
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for scope_waveform_decimator_top.
// Depends on swd_pkg and the decimator RTL; it carries its own pixel predictor.
`default_nettype none
module tb_top;
    import swd_pkg::*;

    localparam int unsigned WIDTH_PX  = 320;
    localparam int unsigned HEIGHT_PX = 240;
    localparam int unsigned SETTLE    = 64;    // lane run plus output stage
    localparam int unsigned STUCK_MAX = 3000;  // cycles with no transaction on either side and no config write

    typedef struct packed {
        logic [7:0] a_high;
        logic [7:0] a_low;
        logic [7:0] b_high;
        logic [7:0] b_low;
        logic       valid;
        logic       last;
    } t_pixel;

    // Pixel predictor plus store of pixels still owed by the block.
    class PixelScoreboard;
        t_pixel            owed[$];
        int                mismatches;
        logic [12:0]       group_len_cfg;
        logic [1:0]        mode_cfg;
        logic [15:0]       num_cfg;
        logic [15:0]       den_cfg;
        logic signed [8:0] offset_cfg;
        logic [7:0]        zero_code_cfg;
        logic [7:0]        zero_row_cfg;
        logic [19:0]       total_a, total_b;
        logic [7:0]        head_a, head_b, lo_a, hi_a, lo_b, hi_b;
        logic [12:0]       fill;
        logic [8:0]        column;

        function new();
            group_len_cfg = 13'd1;
            mode_cfg      = MODE_FIRST;
            num_cfg       = 16'd1;
            den_cfg       = 16'd1;
            offset_cfg    = '0;
            zero_code_cfg = 8'd128;
            zero_row_cfg  = 8'd120;
            mismatches    = 0;
            column        = '0;
            empty_group();
        endfunction

        function void empty_group();
            total_a = '0; total_b = '0;
            head_a = '0; head_b = '0;
            lo_a = 8'hFF; lo_b = 8'hFF;
            hi_a = '0; hi_b = '0;
            fill = '0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [15:0] data);
            case (idx)
                REG_SAMPLES_PER_PIXEL: group_len_cfg = data[12:0];
                REG_REDUCE_MODE:       mode_cfg      = data[1:0];
                REG_SCALE_NUM:         num_cfg       = data;
                REG_SCALE_DEN:         den_cfg       = data;
                REG_VERT_OFFSET:       offset_cfg    = data[8:0];
                REG_RAW_ZERO:          zero_code_cfg = data[7:0];
                REG_ZERO_PIXEL:        zero_row_cfg  = data[7:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] raw_to_row(logic [19:0] raw);
            longint divisor, row;
            divisor = (den_cfg == 0) ? 1 : longint'(den_cfg);
            row = (longint'(num_cfg) * (longint'(raw) - longint'(zero_code_cfg))) / divisor;
            row = row + longint'(offset_cfg) + longint'(zero_row_cfg);
            if (row < 0) row = 0;
            if (row > HEIGHT_PX - 1) row = HEIGHT_PX - 1;
            return row[7:0];
        endfunction

        function void close_column(ref t_pixel px);
            px.last = (column >= WIDTH_PX - 1);
            column  = px.last ? '0 : column + 9'd1;
        endfunction

        // Called for every accepted input transaction.
        function void note_sample(logic [7:0] a, logic [7:0] b, logic present, logic gend);
            t_pixel      px;
            logic [12:0] limit, n;
            if (!present) begin
                empty_group();
                px = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0};
                close_column(px);
                owed.push_back(px);
                return;
            end
            if (fill == 0) begin
                head_a = a; head_b = b;
            end
            total_a += a; total_b += b;
            if (a < lo_a) lo_a = a;
            if (a > hi_a) hi_a = a;
            if (b < lo_b) lo_b = b;
            if (b > hi_b) hi_b = b;
            fill  = fill + 13'd1;
            limit = (group_len_cfg == 0) ? 13'd1 :
                    (group_len_cfg > MAX_GROUP) ? MAX_GROUP : group_len_cfg;
            if (!gend && fill < limit) return;
            n = (fill == 0) ? 13'd1 : fill;
            case (mode_cfg)
                MODE_AVERAGE: begin
                    px.a_high = raw_to_row(total_a / n);
                    px.b_high = raw_to_row(total_b / n);
                    px.a_low  = px.a_high;
                    px.b_low  = px.b_high;
                end
                MODE_PEAK: begin
                    px.a_high = raw_to_row(hi_a);
                    px.a_low  = raw_to_row(lo_a);
                    px.b_high = raw_to_row(hi_b);
                    px.b_low  = raw_to_row(lo_b);
                end
                default: begin  // first sample, unused mode code too
                    px.a_high = raw_to_row(head_a);
                    px.b_high = raw_to_row(head_b);
                    px.a_low  = px.a_high;
                    px.b_low  = px.b_high;
                end
            endcase
            px.valid = 1'b1;
            empty_group();
            close_column(px);
            owed.push_back(px);
        endfunction

        // Called for every accepted output transaction.
        function void check_pixel(t_pixel got);
            t_pixel want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel: a %0d/%0d b %0d/%0d valid %0b last %0b",
                             got.a_high, got.a_low, got.b_high, got.b_low, got.valid,
                             got.last);
                return;
            end
            want = owed.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"pixel mismatch: expected a %0d/%0d b %0d/%0d v %0b l %0b,",
                              " got a %0d/%0d b %0d/%0d v %0b l %0b"},
                             want.a_high, want.a_low, want.b_high, want.b_low, want.valid,
                             want.last, got.a_high, got.a_low, got.b_high, got.b_low,
                             got.valid, got.last);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [7:0]            i_sample_a, i_sample_b;
    logic                  i_present, i_group_end;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [7:0]            o_pixel_a_high, o_pixel_a_low, o_pixel_b_high, o_pixel_b_low;
    logic                  o_pixel_valid, o_last_pixel;

    PixelScoreboard pixels;
    bit             in_steady, out_steady;  // phases with no idling on that side
    int             out_hold;
    int             quiet_cycles;

    scope_waveform_decimator_top #(
        .SCREEN_WIDTH (WIDTH_PX),
        .SCREEN_HEIGHT(HEIGHT_PX)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample_a    (i_sample_a),
        .i_sample_b    (i_sample_b),
        .i_present     (i_present),
        .i_group_end   (i_group_end),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_a_high(o_pixel_a_high),
        .o_pixel_a_low (o_pixel_a_low),
        .o_pixel_b_high(o_pixel_b_high),
        .o_pixel_b_low (o_pixel_b_low),
        .o_pixel_valid (o_pixel_valid),
        .o_last_pixel  (o_last_pixel)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: draws a stall length per pixel; outputs are read before the
    // block's own updates land, so each check sees the values of this edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_hold    = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                pixels.check_pixel('{o_pixel_a_high, o_pixel_a_low, o_pixel_b_high,
                                     o_pixel_b_low, o_pixel_valid, o_last_pixel});
                out_hold = out_steady ? 0 : $urandom_range(15);
            end else if (out_hold > 0) begin
                out_hold = out_hold - 1;
            end
            i_out_stall <= (out_hold > 0);
        end
    end

    // Watchdog: any transaction on either side or config write restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STUCK_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One sample transaction; valid stays high after acceptance so that
    // back-to-back transactions never lower and raise it in one step.
    task automatic send_sample(logic [7:0] a, logic [7:0] b, logic present, logic gend);
        int gap;
        gap = in_steady ? 0 : $urandom_range(15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_a  <= a;
        i_sample_b  <= b;
        i_present   <= present;
        i_group_end <= gend;
        do @(posedge i_clk); while (o_in_stall);
        pixels.note_sample(a, b, present, gend);
    endtask

    // Random samples; group_end comes once in gend_odds+1 samples on average.
    task automatic send_random(int count, int gend_odds);
        repeat (count)
            send_sample(8'($urandom_range(255)), 8'($urandom_range(255)),
                        $urandom_range(11) != 0, $urandom_range(gend_odds) == 0);
    endtask

    // Block must be idle: drop valid at once, drain owed pixels, then let any
    // lane run finish.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pixels.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [15:0] group_len, logic [1:0] mode, logic [15:0] num,
                              logic [15:0] den, logic [8:0] offset, logic [7:0] zero_code,
                              logic [7:0] zero_row);
        logic [15:0] vals[7];
        vals = '{group_len, {14'd0, mode}, num, den, {7'd0, offset}, {8'd0, zero_code},
                 {8'd0, zero_row}};
        for (int i = 0; i < 7; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_reg_idx'(i);
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            pixels.set_reg(t_reg_idx'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
        in_steady  = ($urandom_range(3) == 0);
        out_steady = ($urandom_range(3) == 0);
    endtask

    initial begin
        pixels      = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_sample_a  = '0;
        i_sample_b  = '0;
        i_present   = 1'b0;
        i_group_end = 1'b0;
        in_steady   = 1'b0;
        out_steady  = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset settings: code extremes, absent slots.
        send_sample(8'd0, 8'd255, 1'b1, 1'b0);
        send_sample(8'd255, 8'd0, 1'b1, 1'b1);
        send_sample(8'd128, 8'd127, 1'b0, 1'b0);
        send_sample(8'd170, 8'd85, 1'b0, 1'b1);
        drain();
        // Average, group of three, early close, row overflow.
        write_regs(16'd3, MODE_AVERAGE, 16'd3, 16'd2, 9'h100, 8'd0, 8'd255);
        send_sample(8'd255, 8'd0, 1'b1, 1'b0);
        send_sample(8'd254, 8'd1, 1'b1, 1'b0);
        send_sample(8'd253, 8'd2, 1'b1, 1'b0);
        send_sample(8'd10, 8'd20, 1'b1, 1'b0);
        send_sample(8'd30, 8'd40, 1'b1, 1'b1);
        send_sample(8'd50, 8'd60, 1'b1, 1'b0);
        send_sample(8'd0, 8'd0, 1'b0, 1'b0);   // absent slot discards the partial group
        drain();
        // Peak, group size zero, zero denominator, widest scale.
        write_regs(16'd0, MODE_PEAK, 16'hFFFF, 16'd0, 9'h0FF, 8'd255, 8'd0);
        send_sample(8'd255, 8'd0, 1'b1, 1'b0);
        send_sample(8'd0, 8'd255, 1'b1, 1'b1);
        drain();
        // Unused mode code, zero numerator, widest denominator.
        write_regs(16'd4, 2'd3, 16'd0, 16'hFFFF, 9'h1FB, 8'd128, 8'd120);
        send_sample(8'd1, 8'd2, 1'b1, 1'b0);
        send_sample(8'd3, 8'd4, 1'b1, 1'b0);
        send_sample(8'd5, 8'd6, 1'b1, 1'b0);
        send_sample(8'd7, 8'd8, 1'b1, 1'b0);
        drain();
        // Oversized group register must not close a short group by itself.
        write_regs(16'h1FFF, MODE_PEAK, 16'd1, 16'd1, 9'd0, 8'd128, 8'd120);
        in_steady = 1'b1;
        repeat (12) send_sample(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1, 1'b0);
        send_sample(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1, 1'b1);
        drain();
        write_regs(16'd4096, MODE_AVERAGE, 16'd7, 16'd3, 9'd0, 8'd128, 8'd120);
        send_random(20, 6);
        drain();

        // Random phases: mostly small groups so that pixels come often.
        for (int ph = 0; ph < 5; ph++) begin
            write_regs(16'($urandom_range(1, 6)), 2'($urandom_range(2)),
                       16'($urandom_range(65535)), 16'($urandom_range(65535)),
                       9'($urandom_range(511)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
            send_random(15, 5);
            drain();
        end
        // Frame wrap: long run of single-sample pixels past the last column.
        write_regs(16'd1, MODE_FIRST, 16'd1, 16'd1, 9'd0, 8'd128, 8'd120);
        in_steady = 1'b1;
        send_random(325, 3);
        drain();

        if (pixels.mismatches == 0 && pixels.owed.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/swd_pkg.sv
rtl/core/swd_lane.sv
rtl/core/scope_waveform_decimator_top.sv
test/tb_top.sv
